[hw/rtl/savl_pkg.sv]
// Shared types, register indexes and tap helpers for the state-aggregation value learner.
package savl_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;
    localparam int TAP_W = 3;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INV_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INV_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LRATE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KERN0 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_KERN1 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_KERN2 = 3'd7;

    // Controller to datapath commands
    typedef struct packed {
        logic             clr;
        logic             load_in;
        logic             bin;
        logic             rd;
        logic             mac;
        logic             pred;
        logic             err;
        logic             base;
        logic             urd;
        logic             uwr;
        logic             out_load;
        logic [TAP_W-1:0] tap;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic is_update;
        logic out_free;
    } t_stat;

    // Tap order: chosen action, then per distance the upper and the lower neighbor
    function automatic logic [1:0] tap_dist(input logic [TAP_W-1:0] tap);
        logic [1:0] d;
        case (tap)
            3'd0:          d = 2'd0;
            3'd1, 3'd2:    d = 2'd1;
            3'd3, 3'd4:    d = 2'd2;
            default:       d = 2'd0;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/savl_ctrl.sv]
// Sequencer for the learner: clearing pass, bin, prediction reads, update read-modify-writes.
module savl_ctrl #(
    parameter int KERNEL_TAPS = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  savl_pkg::t_stat i_stat,
    output savl_pkg::t_cmd  o_cmd
);

    localparam int NTAPS = 2 * KERNEL_TAPS - 1;
    localparam logic [savl_pkg::TAP_W-1:0] LAST_TAP = savl_pkg::TAP_W'(NTAPS - 1);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_BIN   = 11'b000_0000_0100,
        S_RD    = 11'b000_0000_1000,
        S_MAC   = 11'b000_0001_0000,
        S_PRED  = 11'b000_0010_0000,
        S_ERR   = 11'b000_0100_0000,
        S_BASE  = 11'b000_1000_0000,
        S_URD   = 11'b001_0000_0000,
        S_UWR   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [savl_pkg::TAP_W-1:0] r_tap, n_tap;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_cmd   = '0;
        o_cmd.tap = r_tap;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_BIN;
                end
            end
            S_BIN: begin
                o_cmd.bin = 1'b1;
                n_tap = '0;
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_tap == LAST_TAP) begin
                    n_state = S_PRED;
                end else begin
                    n_tap = r_tap + 1'b1;
                    n_state = S_RD;
                end
            end
            S_PRED: begin
                o_cmd.pred = 1'b1;
                n_state = i_stat.is_update ? S_ERR : S_DONE;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state = S_BASE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_tap = '0;
                n_state = S_URD;
            end
            S_URD: begin
                o_cmd.urd = 1'b1;
                n_state = S_UWR;
            end
            S_UWR: begin
                o_cmd.uwr = 1'b1;
                if (r_tap == LAST_TAP) begin
                    n_state = S_DONE;
                end else begin
                    n_tap = r_tap + 1'b1;
                    n_state = S_URD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

`ifndef SYNTH
    a_mac_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mac |-> $past(o_cmd.rd)) else $error("accumulate without a read");
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.uwr |-> $past(o_cmd.urd)) else $error("table write without a read");
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap <= LAST_TAP) else $error("tap counter past last tap");
    a_err_after_pred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.err |-> $past(o_cmd.pred)) else $error("error step out of order");
`endif

endmodule

[hw/rtl/savl_dp.sv]
// Datapath: config registers, binning, value table, accumulator, update arithmetic, output register.
module savl_dp #(
    parameter int BINS_PER_DIM = 16,
    parameter int ACTIONS      = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  savl_pkg::t_cmd                i_cmd,
    output savl_pkg::t_stat               o_stat,
    input  logic                          i_req_type,
    input  logic signed [15:0]            i_state_x,
    input  logic signed [15:0]            i_state_y,
    input  logic [1:0]                    i_action,
    input  logic signed [15:0]            i_target,
    input  logic                          i_cfg_valid,
    input  logic [savl_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [15:0]            o_result_value
);

    localparam int CELLS  = BINS_PER_DIM * BINS_PER_DIM;
    localparam int DEPTH  = CELLS * ACTIONS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BIN_W  = $clog2(BINS_PER_DIM);
    localparam int ACT_W  = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;

    // Configuration registers
    logic signed [15:0] r_min_x, r_min_y;
    logic [15:0]        r_inv_x, r_inv_y, r_lrate;
    logic [15:0]        r_kern [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x   <= '0;
            r_min_y   <= '0;
            r_inv_x   <= 16'd256;
            r_inv_y   <= 16'd256;
            r_lrate   <= '0;
            r_kern[0] <= 16'hFFFF;
            r_kern[1] <= '0;
            r_kern[2] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                savl_pkg::REG_MIN_X: r_min_x   <= i_cfg_data;
                savl_pkg::REG_MIN_Y: r_min_y   <= i_cfg_data;
                savl_pkg::REG_INV_X: r_inv_x   <= i_cfg_data;
                savl_pkg::REG_INV_Y: r_inv_y   <= i_cfg_data;
                savl_pkg::REG_LRATE: r_lrate   <= i_cfg_data;
                savl_pkg::REG_KERN0: r_kern[0] <= i_cfg_data;
                savl_pkg::REG_KERN1: r_kern[1] <= i_cfg_data;
                savl_pkg::REG_KERN2: r_kern[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture
    logic signed [15:0] r_sx, r_sy, r_target;
    logic               r_upd;
    logic [ACT_W-1:0]   r_act;
    logic [ACT_W-1:0]   w_act_in;

    assign w_act_in = (32'(i_action) > ACTIONS - 1) ? ACT_W'(ACTIONS - 1) : ACT_W'(i_action);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sx     <= i_state_x;
            r_sy     <= i_state_y;
            r_target <= i_target;
            r_upd    <= i_req_type;
            r_act    <= w_act_in;
        end
    end

    // Binning: floor((s - min) * inv / 2^16), clamped to the grid
    function automatic logic [BIN_W-1:0] bin_of(input logic signed [15:0] s,
                                                input logic signed [15:0] mn,
                                                input logic [15:0] inv);
        logic signed [16:0] d;
        logic [31:0]        p;
        logic [BIN_W-1:0]   b;
        d = {s[15], s} - {mn[15], mn};
        p = d[15:0] * inv;
        if (d[16] || d == '0) b = '0;
        else if (32'(p[31:16]) > BINS_PER_DIM - 1) b = BIN_W'(BINS_PER_DIM - 1);
        else b = BIN_W'(p[31:16]);
        return b;
    endfunction

    logic [BIN_W-1:0] r_bx, r_by;

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin) begin
            r_bx <= bin_of(r_sx, r_min_x, r_inv_x);
            r_by <= bin_of(r_sy, r_min_y, r_inv_y);
        end
    end

    // Tap action and table address
    logic [1:0]       w_dist;
    logic [ACT_W:0]   w_hi, w_dext;
    logic [ACT_W-1:0] w_tact;
    logic [ADDR_W-1:0] w_addr;
    logic [15:0]      w_kern;

    assign w_dist = savl_pkg::tap_dist(i_cmd.tap);
    assign w_kern = r_kern[w_dist];
    assign w_hi   = {1'b0, r_act} + (ACT_W+1)'(w_dist);
    assign w_dext = (ACT_W+1)'(w_dist);

    always_comb begin
        if (i_cmd.tap == '0) begin
            w_tact = r_act;
        end else if (i_cmd.tap[0]) begin
            w_tact = (w_hi > (ACT_W+1)'(ACTIONS - 1)) ? ACT_W'(ACTIONS - 1) : w_hi[ACT_W-1:0];
        end else begin
            w_tact = ({1'b0, r_act} < w_dext) ? '0 : ACT_W'({1'b0, r_act} - w_dext);
        end
    end

    assign w_addr = ADDR_W'(r_bx) * ADDR_W'(BINS_PER_DIM) + ADDR_W'(r_by)
                  + ADDR_W'(w_tact) * ADDR_W'(CELLS);

    // Value table, single port, with clearing sweep after reset
    logic signed [15:0] r_mem [DEPTH];
    logic signed [15:0] r_rdata;
    logic [ADDR_W-1:0]  r_clr;
    logic               w_we;
    logic [ADDR_W-1:0]  w_maddr;
    logic signed [15:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr) r_clr <= r_clr + 1'b1;
    end

    assign o_stat.clr_last = (r_clr == ADDR_W'(DEPTH - 1));
    assign w_maddr = i_cmd.clr ? r_clr : w_addr;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_maddr] <= w_wdata;
        if (i_cmd.rd || i_cmd.urd) r_rdata <= r_mem[w_maddr];
    end

    // Prediction accumulator
    logic signed [35:0] r_acc;
    logic signed [32:0] w_mprod;
    logic signed [35:0] w_rnd;
    logic signed [19:0] w_pshift;
    logic signed [15:0] r_pred;

    assign w_mprod  = $signed({1'b0, w_kern}) * r_rdata;
    assign w_rnd    = r_acc + 36'sd32768;
    assign w_pshift = w_rnd[35:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin) r_acc <= '0;
        else if (i_cmd.mac) r_acc <= r_acc + 36'(w_mprod);
        if (i_cmd.pred) begin
            if (w_pshift > 20'sd32767) r_pred <= 16'sh7FFF;
            else if (w_pshift < -20'sd32768) r_pred <= 16'sh8000;
            else r_pred <= w_pshift[15:0];
        end
    end

    // Error and update step
    logic signed [16:0] w_diff;
    logic signed [15:0] r_err;
    logic signed [32:0] r_base;
    logic signed [49:0] r_uprod;
    logic signed [49:0] w_urnd;
    logic signed [17:0] w_delta;
    logic signed [18:0] w_sum;

    assign w_diff = {r_target[15], r_target} - {r_pred[15], r_pred};

    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            if (w_diff > 17'sd32767) r_err <= 16'sh7FFF;
            else if (w_diff < -17'sd32768) r_err <= 16'sh8000;
            else r_err <= w_diff[15:0];
        end
        if (i_cmd.base) r_base <= r_err * $signed({1'b0, r_lrate});
        if (i_cmd.urd) r_uprod <= r_base * $signed({1'b0, w_kern});
    end

    assign w_urnd  = r_uprod + 50'sh0_0000_8000_0000;
    assign w_delta = w_urnd[49:32];
    assign w_sum   = 19'(r_rdata) + 19'(w_delta);

    always_comb begin
        w_we    = i_cmd.clr || i_cmd.uwr;
        w_wdata = '0;
        if (i_cmd.uwr) begin
            if (w_sum > 19'sd32767) w_wdata = 16'sh7FFF;
            else if (w_sum < -19'sd32768) w_wdata = 16'sh8000;
            else w_wdata = w_sum[15:0];
        end
    end

    // Output register
    logic               r_out_valid;
    logic signed [15:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.out_load) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_res <= r_upd ? r_err : r_pred;
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_res;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.is_update = r_upd;

endmodule

[hw/rtl/state_aggregation_value_learner.sv]
// Top level of the state-aggregation value learner: controller plus datapath.
//
//  channel | valid / ready              | payload
//  in      | i_in_valid / o_in_ready    | i_req_type i_state_x i_state_y i_action i_target
//  out     | o_out_valid / i_out_ready  | o_result_value
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// N = 2*KERNEL_TAPS-1 table taps; every tap costs a read and a use (and a write) on the
// single table port. After reset a clearing sweep over all BINS_PER_DIM^2*ACTIONS table
// entries (1024 at defaults) zeroes the table before the first request is taken. A
// finished result waits in the output register while the next request is accepted;
// the controller only stalls when a second result is ready and the first has not been
// taken.
module state_aggregation_value_learner #(
    parameter int BINS_PER_DIM = 16,
    parameter int ACTIONS      = 4,
    parameter int KERNEL_TAPS  = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic signed [15:0]             i_state_x,
    input  logic signed [15:0]             i_state_y,
    input  logic [1:0]                     i_action,
    input  logic signed [15:0]             i_target,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [15:0]             o_result_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [savl_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    savl_pkg::t_cmd  w_cmd;
    savl_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    savl_ctrl #(
        .KERNEL_TAPS (KERNEL_TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    savl_dp #(
        .BINS_PER_DIM (BINS_PER_DIM),
        .ACTIONS      (ACTIONS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_req_type     (i_req_type),
        .i_state_x      (i_state_x),
        .i_state_y      (i_state_y),
        .i_action       (i_action),
        .i_target       (i_target),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value)
    );

endmodule
